>>> sv/lpcbd_pkg.sv
// Package for the length-prefixed CAN block deframer: item types and constants.
`timescale 1ns / 1ps
`default_nettype none

package lpcbd_pkg;

  // Largest accepted block length; a larger length byte halts the record
  localparam logic [7:0] MAX_BLOCK = 8'd40;

  // Header nibble masks, id alignment, data byte limit and id length offset
  localparam logic [7:0] DLC_MASK  = 8'h0F;
  localparam logic [7:0] FLAG_MASK = 8'hF0;
  localparam int unsigned IdShift  = 5;
  localparam logic [3:0] MAX_DATA  = 4'd8;
  localparam logic [5:0] ID_EXTRA  = 6'd2;

  // Parser phases, one-hot
  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_HDR  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  // One input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       rec_last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [3:0]  dlc;
    logic [3:0]  flag_bits;
    logic        id_present;
    logic [10:0] frame_id;
    logic [3:0]  data_len;
    logic [63:0] data_bytes;
  } out_item_t;

endpackage : lpcbd_pkg

`default_nettype wire

>>> sv/length_prefixed_can_block_deframer_top.sv
// Length-prefixed CAN block deframer: byte parser with a registered result.
// A block's result is registered and valid in the cycle after its last byte.
// Throughput: one byte per cycle; the parse state steps on each accepted byte;
// the result register frees the input side whenever it is empty or being taken.
// Reset: rst_ni clears the parser to the start of a record, skip_leading to 0
// and the result register to empty; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_can_block_deframer_top #(
  parameter logic [7:0] MaxBlock = lpcbd_pkg::MAX_BLOCK
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // byte input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire lpcbd_pkg::in_item_t   in_item_i,
  // block output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output lpcbd_pkg::out_item_t       out_item_o,
  // skip_leading register write
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_data_i
);
  import lpcbd_pkg::*;

  // control state
  phase_e      phase_q, phase_d;
  logic [1:0]  skip_count_q, skip_count_d;
  logic        halted_q, halted_d;
  logic [1:0]  skip_leading_q;
  logic        out_valid_q, out_valid_d;

  // block payload state
  logic [5:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  header_byte_q, header_byte_d;
  logic        id_flag_q, id_flag_d;
  logic [15:0] id_shift_q, id_shift_d;
  logic [63:0] data_shift_q, data_shift_d;
  logic [3:0]  data_count_q, data_count_d;
  out_item_t   out_item_q, out_item_d;

  logic        in_accept;
  logic        emit;
  logic [7:0]  b;
  logic [3:0]  hdr_dlc;
  logic [5:0]  left_dec;
  phase_e      eff_phase;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign b           = in_item_i.in_byte;
  assign hdr_dlc     = header_byte_q[3:0];
  assign left_dec    = bytes_left_q - 6'd1;

  // per-byte parse step
  always_comb begin
    phase_d      = phase_q;
    skip_count_d = skip_count_q;
    halted_d     = halted_q;
    bytes_left_d = bytes_left_q;
    header_byte_d = header_byte_q;
    id_flag_d    = id_flag_q;
    id_shift_d   = id_shift_q;
    data_shift_d = data_shift_q;
    data_count_d = data_count_q;
    emit         = 1'b0;
    eff_phase    = phase_q;

    if (!halted_q) begin
      // skip phase: consume a byte or fall through to the length byte
      if (phase_q == PH_SKIP) begin
        if (skip_count_q < skip_leading_q) begin
          skip_count_d = skip_count_q + 2'd1;
        end else begin
          eff_phase = PH_LEN;
          phase_d   = PH_LEN;
        end
      end

      unique case (eff_phase)
        PH_LEN: begin
          if (b == 8'd0 || b > MaxBlock) begin
            halted_d = 1'b1;
          end else begin
            bytes_left_d = b[5:0];
            phase_d      = PH_HDR;
          end
        end
        PH_HDR: begin
          header_byte_d = b;
          bytes_left_d  = left_dec;
          id_flag_d     = (left_dec == ({2'b00, b[3:0]} + ID_EXTRA));
          id_shift_d    = '0;
          data_shift_d  = '0;
          data_count_d  = '0;
          if (left_dec == 6'd0) begin
            emit    = 1'b1;
            phase_d = PH_LEN;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (id_flag_q && bytes_left_q > {2'b00, hdr_dlc}) begin
            id_shift_d = {id_shift_q[7:0], b};
          end else if (data_count_q < MAX_DATA) begin
            data_shift_d = data_shift_q | (64'(b) << {data_count_q[2:0], 3'b000});
            data_count_d = data_count_q + 4'd1;
          end
          bytes_left_d = left_dec;
          if (left_dec == 6'd0) begin
            emit    = 1'b1;
            phase_d = PH_LEN;
          end
        end
        PH_SKIP: begin
          // byte taken by the leading skip
        end
        default: begin
          phase_d = PH_SKIP;
        end
      endcase
    end

    // end of record restarts the parser
    if (in_item_i.rec_last) begin
      phase_d      = PH_SKIP;
      skip_count_d = '0;
      halted_d     = 1'b0;
    end
  end

  // result formed from the updated block state
  always_comb begin
    out_item_d.dlc        = header_byte_d[3:0] & DLC_MASK[3:0];
    out_item_d.flag_bits  = header_byte_d[7:4] & FLAG_MASK[7:4];
    out_item_d.id_present = id_flag_d;
    out_item_d.frame_id   = id_flag_d ? 11'(id_shift_d >> IdShift) : 11'd0;
    out_item_d.data_len   = data_count_d;
    out_item_d.data_bytes = data_shift_d;
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SKIP;
      skip_count_q   <= '0;
      halted_q       <= 1'b0;
      skip_leading_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        skip_leading_q <= cfg_data_i;
      end
      if (in_accept) begin
        phase_q      <= phase_d;
        skip_count_q <= skip_count_d;
        halted_q     <= halted_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bytes_left_q  <= bytes_left_d;
      header_byte_q <= header_byte_d;
      id_flag_q     <= id_flag_d;
      id_shift_q    <= id_shift_d;
      data_shift_q  <= data_shift_d;
      data_count_q  <= data_count_d;
      if (emit) begin
        out_item_q <= out_item_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule : length_prefixed_can_block_deframer_top

`default_nettype wire

>>> verif/lpcbd_checker.sv
`timescale 1ns / 1ps
// Block deframer checker: watches the three channels, predicts each block and compares.
module lpcbd_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  lpcbd_pkg::in_item_t  in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  lpcbd_pkg::out_item_t out_item_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [1:0]           cfg_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   blocks_o
);
  import lpcbd_pkg::*;

  localparam int PrintCap = 30;

  // Predicted parser state
  logic [1:0]  skip_reg;
  phase_e      parse_ph;
  logic [1:0]  skip_cnt;
  logic [5:0]  left_cnt;
  logic [7:0]  hdr_byte;
  logic        id_seen;
  logic [15:0] id_word;
  logic [63:0] data_acc;
  logic [3:0]  data_cnt;
  logic        halt;

  out_item_t blocks_due[$];

  task automatic restart_parse();
    parse_ph = PH_SKIP;
    skip_cnt = '0;
    left_cnt = '0;
    hdr_byte = '0;
    id_seen  = 1'b0;
    id_word  = '0;
    data_acc = '0;
    data_cnt = '0;
    halt     = 1'b0;
  endtask

  // One byte through the parser; a completed block joins the queue
  task automatic parse_byte(input in_item_t it);
    out_item_t blk;
    logic      done;
    logic [7:0] b;
    done = 1'b0;
    b = it.in_byte;
    if (!halt) begin
      if (parse_ph == PH_SKIP) begin
        if (skip_cnt < skip_reg) skip_cnt = skip_cnt + 2'd1;
        else parse_ph = PH_LEN;
      end
      case (parse_ph)
        PH_LEN: begin
          if (b == 8'd0 || b > MAX_BLOCK) begin
            halt = 1'b1;
          end else begin
            left_cnt = b[5:0];
            parse_ph = PH_HDR;
          end
        end
        PH_HDR: begin
          hdr_byte = b;
          left_cnt = left_cnt - 6'd1;
          id_seen  = (left_cnt == {2'b00, b[3:0]} + ID_EXTRA);
          id_word  = '0;
          data_acc = '0;
          data_cnt = '0;
          if (left_cnt == 6'd0) begin
            done = 1'b1;
            parse_ph = PH_LEN;
          end else begin
            parse_ph = PH_BODY;
          end
        end
        PH_BODY: begin
          if (id_seen && left_cnt > {2'b00, hdr_byte[3:0]}) begin
            id_word = {id_word[7:0], b};
          end else if (data_cnt < MAX_DATA) begin
            data_acc[8*data_cnt +: 8] = b;
            data_cnt = data_cnt + 4'd1;
          end
          left_cnt = left_cnt - 6'd1;
          if (left_cnt == 6'd0) begin
            done = 1'b1;
            parse_ph = PH_LEN;
          end
        end
        default: ;
      endcase
    end
    if (done) begin
      blk.dlc        = hdr_byte[3:0];
      blk.flag_bits  = hdr_byte[7:4];
      blk.id_present = id_seen;
      blk.frame_id   = id_seen ? 11'(id_word >> IdShift) : 11'd0;
      blk.data_len   = data_cnt;
      blk.data_bytes = data_acc;
      blocks_due.push_back(blk);
    end
    if (it.rec_last) restart_parse();
  endtask

  task automatic report_mismatch(input string msg);
    errors_o++;
    if (errors_o <= PrintCap) $display("tb: mismatch: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got)
      report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  task automatic check_block(input out_item_t got);
    out_item_t want;
    blocks_o++;
    if (blocks_due.size() == 0) begin
      report_mismatch("block result with none expected");
    end else begin
      want = blocks_due.pop_front();
      compare_field("dlc", want.dlc, got.dlc);
      compare_field("flag_bits", want.flag_bits, got.flag_bits);
      compare_field("id_present", want.id_present, got.id_present);
      compare_field("frame_id", want.frame_id, got.frame_id);
      compare_field("data_len", want.data_len, got.data_len);
      compare_field("data_bytes", want.data_bytes, got.data_bytes);
    end
  endtask

  // Sample mid-cycle: handshakes seen here complete at the next rising edge.
  // A byte taken at the same edge as a register write still sees the old value.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      skip_reg = '0;
      restart_parse();
      blocks_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) parse_byte(in_item_i);
      if (cfg_valid_i && cfg_ready_i) skip_reg = cfg_data_i;
      if (out_valid_i && !out_stall_i) check_block(out_item_i);
    end
    pending_o = blocks_due.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the block deframer: byte stimulus, output stalls and verdict.
module tb;
  import lpcbd_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 300;
  localparam int PhaseBytes = 100;
  localparam int NumPhases  = 8;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i  = 2'd0;

  int errors;
  int pending;
  int blocks_seen;
  int cycles     = 0;
  int bytes_sent = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;

  // skip_leading per random phase, extremes included
  logic [1:0] skip_plan [NumPhases] = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3};

  in_item_t stream[$];

  length_prefixed_can_block_deframer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  lpcbd_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .blocks_o    (blocks_seen)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (pick_gap()) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input in_item_t it);
    bit fire;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(negedge clk_i);
      fire = !in_stall_o;
      @(posedge clk_i);
    end while (!fire);
    bytes_sent++;
  endtask

  task automatic send_stream();
    while (stream.size() != 0) send_item(stream.pop_front());
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected block, then let the parser drain
  task automatic settle();
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_skip(input logic [1:0] value);
    bit fire;
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      fire = cfg_ready_o;
      @(posedge clk_i);
    end while (!fire);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_bytes(input logic [7:0] b[$], input bit close);
    in_item_t it;
    foreach (b[i]) begin
      it.in_byte  = b[i];
      it.rec_last = close && (i == b.size() - 1);
      stream.push_back(it);
    end
  endtask

  // One record: mostly well-formed blocks, some noise, bad lengths and cut blocks
  task automatic build_record(input logic [1:0] skip);
    logic [7:0] bytes[$];
    int kind;
    int len;
    int last_len;
    logic [3:0] dlc;
    kind = $urandom_range(0, 9);
    last_len = 1;
    repeat (skip) bytes.push_back(8'($urandom));
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        // about half the blocks that can carry an id do
        if (len >= 3 && len <= 18 && $urandom_range(0, 1) == 0) dlc = 4'(len - 3);
        else dlc = 4'($urandom);
        bytes.push_back(8'(len));
        bytes.push_back({4'($urandom), dlc});
        repeat (len - 1) bytes.push_back(8'($urandom));
        last_len = len;
      end
      if (kind == 1) begin
        bytes.push_back(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(41, 255)));
        repeat ($urandom_range(0, 5)) bytes.push_back(8'($urandom));
      end else if (kind == 2) begin
        repeat ($urandom_range(1, last_len)) void'(bytes.pop_back());
      end
    end
    add_bytes(bytes, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: header-only block, id block ending on the last byte
    add_bytes('{8'h01, 8'hFF, 8'h05, 8'hA2, 8'hFF, 8'hFF, 8'h00, 8'h11}, 1'b1);
    // zero length, then oversized length, both halt until record end
    add_bytes('{8'h00, 8'h77}, 1'b1);
    add_bytes('{8'd41, 8'h00}, 1'b1);
    // block cut short by the end of the record
    add_bytes('{8'h03, 8'h0F, 8'hAA}, 1'b1);
    // nine data bytes, only eight kept
    add_bytes('{8'h0A, 8'h03, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                8'h08, 8'h09}, 1'b1);
    send_stream();
    // skip of three, the largest value the register holds
    write_skip(2'd3);
    add_bytes('{8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00}, 1'b1);
    send_stream();

    // Random phases, one register setting each
    for (int p = 0; p < NumPhases; p++) begin
      write_skip(skip_plan[p]);
      calm = (p == 5);
      if (p == 2) hold_req = 1'b1;
      while (stream.size() < PhaseBytes) build_record(skip_plan[p]);
      // leave a record open across the next register write
      if (p == 3) begin
        stream[stream.size() - 1].rec_last = 1'b0;
      end
      send_stream();
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("tb: %0d bytes sent, %0d blocks compared", bytes_sent, blocks_seen);
    $display("tb: skip 0..3, halts, cut and open records, id blocks, %0d-cycle hold-off",
             HoldCycles);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
